### sv/aat_pkg.sv
// types and constants for the axis-aligned box affine transform
// no dependencies; used by aabb_affine_transform, aat_chk and tb
package aat_pkg;

    localparam int NUM_REGS  = 6;
    localparam int IDX_W     = 3;
    localparam int LATENCY   = 5;

    localparam logic [IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;

    // identity matrix, one q16.16 entry per 32-bit half
    localparam logic [63:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
    localparam logic [63:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;

    localparam logic [15:0]        ROUND_HALF = 16'h8000;
    localparam logic signed [31:0] S32_MAX    = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN    = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] in_min_x;
        logic signed [31:0] in_min_y;
        logic signed [31:0] in_min_z;
        logic signed [31:0] in_max_x;
        logic signed [31:0] in_max_y;
        logic signed [31:0] in_max_z;
    } t_box_in;

    typedef struct packed {
        logic signed [31:0] out_min_x;
        logic signed [31:0] out_min_y;
        logic signed [31:0] out_min_z;
        logic signed [31:0] out_max_x;
        logic signed [31:0] out_max_y;
        logic signed [31:0] out_max_z;
    } t_box_out;

endpackage

### sv/aabb_affine_transform.sv
// Affine transform of an axis-aligned box: one box per clock cycle, result on a one-cycle
// o_valid strobe after five register stages (products, per-column extreme select, two adds,
// round and saturate); the receiver cannot stall, so nothing holds the stream. busy is high
// only in reset and the cycle after.
// depends on aat_pkg
module aabb_affine_transform (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  aat_pkg::t_box_in          i_box,
    output logic                      o_valid,
    output aat_pkg::t_box_out         o_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [aat_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [63:0]               i_cfg_data
);

    logic [63:0]                   r_cfg [aat_pkg::NUM_REGS];
    logic                          r_run;
    logic [aat_pkg::LATENCY-1:0]   r_vld;

    logic signed [31:0] w_m   [3][4];
    logic signed [31:0] w_lo  [3];
    logic signed [31:0] w_hi  [3];

    logic signed [63:0] n_p_lo [3][3];
    logic signed [63:0] n_p_hi [3][3];
    logic signed [63:0] r_p_lo [3][3];
    logic signed [63:0] r_p_hi [3][3];
    logic signed [63:0] r_mn   [3][3];
    logic signed [63:0] r_mx   [3][3];
    logic signed [64:0] r_s_mn [3];
    logic signed [64:0] r_s_mx [3];
    logic signed [63:0] r_c_mn [3];
    logic signed [63:0] r_c_mx [3];
    logic signed [65:0] r_t_mn [3];
    logic signed [65:0] r_t_mx [3];
    logic signed [31:0] n_o_mn [3];
    logic signed [31:0] n_o_mx [3];
    aat_pkg::t_box_out  r_out;

    logic               w_accept;

    assign busy        = !r_run;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign o_valid     = r_vld[aat_pkg::LATENCY-1];
    assign o_res       = r_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[aat_pkg::REG_ROW0_COLS01] <= aat_pkg::RST_ROW0_COLS01;
            r_cfg[aat_pkg::REG_ROW0_COLS23] <= aat_pkg::RST_ROW0_COLS23;
            r_cfg[aat_pkg::REG_ROW1_COLS01] <= aat_pkg::RST_ROW1_COLS01;
            r_cfg[aat_pkg::REG_ROW1_COLS23] <= aat_pkg::RST_ROW1_COLS23;
            r_cfg[aat_pkg::REG_ROW2_COLS01] <= aat_pkg::RST_ROW2_COLS01;
            r_cfg[aat_pkg::REG_ROW2_COLS23] <= aat_pkg::RST_ROW2_COLS23;
        end else if (i_cfg_valid && o_cfg_ready &&
                     i_cfg_index < aat_pkg::IDX_W'(aat_pkg::NUM_REGS)) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // matrix entries and box bounds
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 4; c++) begin
                w_m[a][c] = $signed(r_cfg[a*2 + c/2][(c%2)*32 +: 32]);
            end
        end
        w_lo[0] = i_box.in_min_x;
        w_lo[1] = i_box.in_min_y;
        w_lo[2] = i_box.in_min_z;
        w_hi[0] = i_box.in_max_x;
        w_hi[1] = i_box.in_max_y;
        w_hi[2] = i_box.in_max_z;
        for (int a = 0; a < 3; a++) begin
            for (int j = 0; j < 3; j++) begin
                n_p_lo[a][j] = 64'(w_m[a][j]) * 64'(w_lo[j]);
                n_p_hi[a][j] = 64'(w_m[a][j]) * 64'(w_hi[j]);
            end
        end
    end

    // round to q16.16 then saturate
    always_comb begin
        logic signed [49:0] q_mn;
        logic signed [49:0] q_mx;
        for (int a = 0; a < 3; a++) begin
            q_mn = r_t_mn[a][65:16];
            q_mx = r_t_mx[a][65:16];
            if (q_mn[49:31] == '0 || q_mn[49:31] == '1) begin
                n_o_mn[a] = q_mn[31:0];
            end else begin
                n_o_mn[a] = q_mn[49] ? aat_pkg::S32_MIN : aat_pkg::S32_MAX;
            end
            if (q_mx[49:31] == '0 || q_mx[49:31] == '1) begin
                n_o_mx[a] = q_mx[31:0];
            end else begin
                n_o_mx[a] = q_mx[49] ? aat_pkg::S32_MIN : aat_pkg::S32_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_vld <= '0;
        end else begin
            r_run <= 1'b1;
            r_vld <= {r_vld[aat_pkg::LATENCY-2:0], w_accept};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            for (int j = 0; j < 3; j++) begin
                r_p_lo[a][j] <= n_p_lo[a][j];
                r_p_hi[a][j] <= n_p_hi[a][j];
                if (r_p_lo[a][j] < r_p_hi[a][j]) begin
                    r_mn[a][j] <= r_p_lo[a][j];
                    r_mx[a][j] <= r_p_hi[a][j];
                end else begin
                    r_mn[a][j] <= r_p_hi[a][j];
                    r_mx[a][j] <= r_p_lo[a][j];
                end
            end
            r_s_mn[a] <= 65'(r_mn[a][0]) + 65'(r_mn[a][1]);
            r_s_mx[a] <= 65'(r_mx[a][0]) + 65'(r_mx[a][1]);
            r_c_mn[a] <= r_mn[a][2];
            r_c_mx[a] <= r_mx[a][2];
            r_t_mn[a] <= 66'(r_s_mn[a]) + 66'(r_c_mn[a])
                       + 66'($signed({w_m[a][3], aat_pkg::ROUND_HALF}));
            r_t_mx[a] <= 66'(r_s_mx[a]) + 66'(r_c_mx[a])
                       + 66'($signed({w_m[a][3], aat_pkg::ROUND_HALF}));
        end
        r_out.out_min_x <= n_o_mn[0];
        r_out.out_min_y <= n_o_mn[1];
        r_out.out_min_z <= n_o_mn[2];
        r_out.out_max_x <= n_o_mx[0];
        r_out.out_max_y <= n_o_mx[1];
        r_out.out_max_z <= n_o_mx[2];
    end

endmodule

### sv/aat_chk.sv
// port-level checks for aabb_affine_transform, bound into every instance of that module
// depends on aat_pkg
module aat_chk (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  aat_pkg::t_box_in          i_box,
    input  logic                      o_valid,
    input  aat_pkg::t_box_out         o_res
);

    logic [aat_pkg::LATENCY-1:0] r_hist;
    logic                        w_settled;
    logic                        w_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else begin
            r_hist <= {r_hist[aat_pkg::LATENCY-2:0], 1'b1};
        end
    end

    assign w_settled = (&r_hist) && i_rst_n;
    assign w_point   = (i_box.in_min_x == i_box.in_max_x) &&
                       (i_box.in_min_y == i_box.in_max_y) &&
                       (i_box.in_min_z == i_box.in_max_z);

    // one result for each transfer, fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!w_settled)
        o_valid == $past(start && !busy, aat_pkg::LATENCY))
        else $error("result strobe does not match transfer latency");

    // extremes are ordered
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.out_min_x <= o_res.out_max_x) &&
                    (o_res.out_min_y <= o_res.out_max_y) &&
                    (o_res.out_min_z <= o_res.out_max_z))
        else $error("result min exceeds max");

    // a point box maps to a point
    a_point: assert property (@(posedge i_clk) disable iff (!w_settled)
        (o_valid && $past(w_point && start && !busy, aat_pkg::LATENCY)) |->
            (o_res.out_min_x == o_res.out_max_x) &&
            (o_res.out_min_y == o_res.out_max_y) &&
            (o_res.out_min_z == o_res.out_max_z))
        else $error("point box gave a non-point result");

    // no strobe while in reset history
    a_quiet: assert property (@(posedge i_clk)
        (!i_rst_n) |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind aabb_affine_transform aat_chk u_aat_chk (.*);

### verif/tb.sv
`timescale 1ns / 1ps
// self-checking bench for aabb_affine_transform: directed rows, then random boxes under
// several matrix settings, checked against an in-bench bounds predictor; uses aat_pkg
module tb;

    localparam logic [aat_pkg::IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [aat_pkg::IDX_W-1:0] REG_UNUSED_HI = 3'd7;
    localparam int WDOG_LIMIT = 500;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 60;

    typedef enum logic {ROW_BOX, ROW_CFG} t_row_kind;
    typedef enum int {MX_ZERO, MX_ONES, MX_EXTREME, MX_SMALL, MX_WILD, MX_MIXED} t_mtx_style;

    typedef struct {
        t_row_kind                   kind;
        logic [aat_pkg::IDX_W-1:0]   idx;
        logic [63:0]                 data;
        aat_pkg::t_box_in            box;
        bit                          has_exp;
        aat_pkg::t_box_out           exp;
    } t_stim_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    aat_pkg::t_box_in          i_box;
    logic                      o_valid;
    aat_pkg::t_box_out         o_res;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [aat_pkg::IDX_W-1:0] i_cfg_index;
    logic [63:0]               i_cfg_data;

    logic [63:0]       mtx_reg [aat_pkg::NUM_REGS];
    aat_pkg::t_box_out want_bounds [$];
    t_stim_row         stim_tab [$];
    int                err_cnt = 0;
    int                wd_cnt = 0;
    string             res_field [6] = '{"out_max_z", "out_max_y", "out_max_x",
                                         "out_min_z", "out_min_y", "out_min_x"};

    aabb_affine_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_box       (i_box),
        .o_valid     (o_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one row of the matrix applied to one corner, rounded half up and saturated
    function automatic logic signed [31:0] xform_coord(int r, logic signed [31:0] x,
                                                       logic signed [31:0] y,
                                                       logic signed [31:0] z);
        logic signed [31:0] m0, m1, m2, m3;
        logic signed [79:0] acc;
        m0 = mtx_reg[2*r][31:0];
        m1 = mtx_reg[2*r][63:32];
        m2 = mtx_reg[2*r+1][31:0];
        m3 = mtx_reg[2*r+1][63:32];
        acc = m0 * x + m1 * y + m2 * z + $signed({1'b0, aat_pkg::ROUND_HALF});
        acc = (acc >>> 16) + m3;
        if (acc > aat_pkg::S32_MAX) return aat_pkg::S32_MAX;
        if (acc < aat_pkg::S32_MIN) return aat_pkg::S32_MIN;
        return acc[31:0];
    endfunction

    function automatic aat_pkg::t_box_out xform_bounds(aat_pkg::t_box_in b);
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        logic signed [31:0] mn [3];
        logic signed [31:0] mx [3];
        logic signed [31:0] v;
        lo[0] = b.in_min_x; lo[1] = b.in_min_y; lo[2] = b.in_min_z;
        hi[0] = b.in_max_x; hi[1] = b.in_max_y; hi[2] = b.in_max_z;
        for (int k = 0; k < 8; k++) begin
            for (int a = 0; a < 3; a++) begin
                v = xform_coord(a, (k & 1) ? hi[0] : lo[0], (k & 2) ? hi[1] : lo[1],
                                (k & 4) ? hi[2] : lo[2]);
                if (k == 0 || v < mn[a]) mn[a] = v;
                if (k == 0 || v > mx[a]) mx[a] = v;
            end
        end
        return {mn[0], mn[1], mn[2], mx[0], mx[1], mx[2]};
    endfunction

    function automatic logic [31:0] rand_entry(t_mtx_style s);
        case (s)
            MX_ZERO: return '0;
            MX_ONES: return '1;
            MX_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return aat_pkg::S32_MIN;
                    1: return aat_pkg::S32_MAX;
                    2: return 32'sh0001_0000;
                    default: return 32'shFFFF_0000;
                endcase
            end
            MX_SMALL: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            MX_WILD: return $urandom;
            default: return rand_entry(t_mtx_style'($urandom_range(MX_EXTREME, MX_WILD)));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return aat_pkg::S32_MIN;
            1: return aat_pkg::S32_MAX;
            2: return '0;
            3: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
            4, 5, 6: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-ordered boxes, the rest with each axis left in random order
    function automatic aat_pkg::t_box_in rand_box();
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        logic signed [31:0] t;
        bit ordered;
        ordered = $urandom_range(0, 9) < 7;
        for (int a = 0; a < 3; a++) begin
            lo[a] = rand_coord();
            hi[a] = rand_coord();
            if (ordered && lo[a] > hi[a]) begin
                t = lo[a];
                lo[a] = hi[a];
                hi[a] = t;
            end
        end
        return {lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    endfunction

    function automatic void tab_box(aat_pkg::t_box_in b);
        t_stim_row r;
        r.kind = ROW_BOX;
        r.box = b;
        r.has_exp = 1'b0;
        stim_tab.insert(stim_tab.size(), r);
    endfunction

    function automatic void tab_box_exp(aat_pkg::t_box_in b, aat_pkg::t_box_out e);
        t_stim_row r;
        r.kind = ROW_BOX;
        r.box = b;
        r.has_exp = 1'b1;
        r.exp = e;
        stim_tab.insert(stim_tab.size(), r);
    endfunction

    function automatic void tab_cfg(logic [aat_pkg::IDX_W-1:0] idx, logic [63:0] data);
        t_stim_row r;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        stim_tab.insert(stim_tab.size(), r);
    endfunction

    // called at a falling edge, returns at a falling edge with valid low
    task automatic write_reg(logic [aat_pkg::IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < aat_pkg::NUM_REGS) mtx_reg[idx] = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_box(aat_pkg::t_box_in b, aat_pkg::t_box_out e, int gap_pct);
        if ($urandom_range(1, 100) <= gap_pct) begin
            start <= 1'b0;
            i_box <= rand_box();
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_box <= b;
        do @(posedge i_clk); while (busy);
        want_bounds.insert(want_bounds.size(), e);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (want_bounds.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        aat_pkg::t_box_out e;
        if (i_rst_n && o_valid) begin
            if (want_bounds.size() == 0) begin
                $display("%0t unexpected result: got %h", $time, o_res);
                err_cnt++;
            end else begin
                e = want_bounds.pop_front();
                for (int f = 0; f < 6; f++) begin
                    if (o_res[32*f +: 32] !== e[32*f +: 32]) begin
                        $display("%0t %s mismatch: expected %h, got %h", $time,
                                 res_field[f], e[32*f +: 32], o_res[32*f +: 32]);
                        err_cnt++;
                    end
                end
            end
        end
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            wd_cnt <= 0;
        else
            wd_cnt <= wd_cnt + 1;
        if (wd_cnt >= WDOG_LIMIT) begin
            $display("%0t watchdog expired", $time);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int gap_sched [NUM_PHASES];
        t_mtx_style sty;
        aat_pkg::t_box_in b;

        gap_sched   = '{0, 83, 10, 0, 83, 10, 83, 0};
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_box       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        mtx_reg[aat_pkg::REG_ROW0_COLS01] = aat_pkg::RST_ROW0_COLS01;
        mtx_reg[aat_pkg::REG_ROW0_COLS23] = aat_pkg::RST_ROW0_COLS23;
        mtx_reg[aat_pkg::REG_ROW1_COLS01] = aat_pkg::RST_ROW1_COLS01;
        mtx_reg[aat_pkg::REG_ROW1_COLS23] = aat_pkg::RST_ROW1_COLS23;
        mtx_reg[aat_pkg::REG_ROW2_COLS01] = aat_pkg::RST_ROW2_COLS01;
        mtx_reg[aat_pkg::REG_ROW2_COLS23] = aat_pkg::RST_ROW2_COLS23;

        // identity after reset
        tab_box_exp({32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                     32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000},
                    {32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                     32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000});
        tab_box_exp('0, '0);
        tab_box_exp({aat_pkg::S32_MIN, aat_pkg::S32_MIN, aat_pkg::S32_MIN,
                     aat_pkg::S32_MAX, aat_pkg::S32_MAX, aat_pkg::S32_MAX},
                    {aat_pkg::S32_MIN, aat_pkg::S32_MIN, aat_pkg::S32_MIN,
                     aat_pkg::S32_MAX, aat_pkg::S32_MAX, aat_pkg::S32_MAX});
        // inverted box
        tab_box_exp({aat_pkg::S32_MAX, aat_pkg::S32_MAX, aat_pkg::S32_MAX,
                     aat_pkg::S32_MIN, aat_pkg::S32_MIN, aat_pkg::S32_MIN},
                    {aat_pkg::S32_MIN, aat_pkg::S32_MIN, aat_pkg::S32_MIN,
                     aat_pkg::S32_MAX, aat_pkg::S32_MAX, aat_pkg::S32_MAX});
        tab_box_exp({6{aat_pkg::S32_MAX}}, {6{aat_pkg::S32_MAX}});
        tab_box_exp({6{aat_pkg::S32_MIN}}, {6{aat_pkg::S32_MIN}});
        tab_box({32'shFFFE_8000, 32'shFFFF_C000, 32'shFFFF_FFFF,
                 32'sh0000_0001, 32'sh0000_8000, 32'sh7FFF_0000});
        // writes to unused indexes leave the identity in place
        tab_cfg(REG_UNUSED_LO, '1);
        tab_cfg(REG_UNUSED_HI, 64'h5A5A_A5A5_0F0F_F0F0);
        tab_box_exp({32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                     32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000},
                    {32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                     32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000});
        // scale, translation, extreme entries, half-ulp rounding
        tab_cfg(aat_pkg::REG_ROW0_COLS01, {32'shFFFF_0000, 32'sh0002_0000});
        tab_cfg(aat_pkg::REG_ROW0_COLS23, {32'sh0064_0000, 32'sh0000_8000});
        tab_cfg(aat_pkg::REG_ROW1_COLS01, {aat_pkg::S32_MAX, aat_pkg::S32_MIN});
        tab_cfg(aat_pkg::REG_ROW1_COLS23, '1);
        tab_cfg(aat_pkg::REG_ROW2_COLS01, {32'sh0000_8000, 32'sh0000_8000});
        tab_cfg(aat_pkg::REG_ROW2_COLS23, {32'sh0000_0000, 32'shFFFF_8000});
        tab_box({32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                 32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000});
        tab_box({aat_pkg::S32_MIN, aat_pkg::S32_MIN, aat_pkg::S32_MIN,
                 aat_pkg::S32_MAX, aat_pkg::S32_MAX, aat_pkg::S32_MAX});
        tab_box({32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_0000,
                 32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0000});
        tab_box({32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0000_0001,
                 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF});
        tab_box({32'sh0010_0000, 32'sh0000_0000, 32'sh0000_0000,
                 32'shFFF0_0000, 32'sh0000_0000, 32'sh0000_0000});
        tab_box({6{aat_pkg::S32_MAX}});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_tab[i]) begin
            if (stim_tab[i].kind == ROW_CFG) begin
                drain();
                write_reg(stim_tab[i].idx, stim_tab[i].data);
            end else begin
                send_box(stim_tab[i].box,
                         stim_tab[i].has_exp ? stim_tab[i].exp : xform_bounds(stim_tab[i].box),
                         0);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            sty = (ph < 3) ? t_mtx_style'(ph) : t_mtx_style'($urandom_range(MX_EXTREME, MX_MIXED));
            for (int r = 0; r < aat_pkg::NUM_REGS; r++)
                write_reg(aat_pkg::IDX_W'(r), {rand_entry(sty), rand_entry(sty)});
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                          {$urandom, $urandom});
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                b = rand_box();
                send_box(b, xform_bounds(b), gap_sched[ph]);
            end
        end

        drain();
        repeat (aat_pkg::LATENCY + 4) @(posedge i_clk);
        if (err_cnt == 0 && want_bounds.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
sv/aat_pkg.sv
sv/aabb_affine_transform.sv
sv/aat_chk.sv
verif/tb.sv
